// ===== hdl/srt_pkg.sv =====
// Shared types and constants of the sorted region table.
// Used by srt_range and sorted_region_table_core; depends on nothing else.
`default_nettype none

package srt_pkg;

  localparam int ADDR_W = 39;
  localparam int FLAG_W = 4;
  localparam int STAT_W = 2;

  // Table depth; the fill count must also hold the depth itself.
  localparam int MAX_REGIONS = 32;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // The page size must be a power of two.
  localparam int unsigned PAGE_SIZE = 4096;
  localparam int RND_W = ADDR_W + 2;
  localparam logic [RND_W-1:0] PAGE_MASK = RND_W'(PAGE_SIZE - 1);

  localparam int IN_DATA_W = ((2 * ADDR_W + FLAG_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * ADDR_W + FLAG_W + 7) / 8) * 8;
  localparam int IN_PAD_W = IN_DATA_W - 2 * ADDR_W - FLAG_W;
  localparam int OUT_PAD_W = OUT_DATA_W - 2 * ADDR_W - FLAG_W;
  localparam int OUT_USER_W = STAT_W + 1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_MAP = 1'b1;

  localparam logic CFG_USER_BASE = 1'b0;
  localparam logic CFG_USER_TOP = 1'b1;

  localparam logic [ADDR_W-1:0] USER_BASE_RST = ADDR_W'(64'd2097152);
  localparam logic [ADDR_W-1:0] USER_TOP_RST = ADDR_W'(64'd2147483648);

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_OVERLAP = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_POST,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] start_addr;
  } entry_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
  } range_t;

  typedef struct packed {
    status_e status;
    logic    hit;
    entry_t  region;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/srt_range.sv =====
// Page rounding of a map request and its check against the user window.
// Depends on srt_pkg.
`default_nettype none

module srt_range (
  input  wire logic [srt_pkg::ADDR_W-1:0] addr_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] length_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] user_base_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] user_top_i,
  output srt_pkg::range_t                 range_o
);

  logic [srt_pkg::ADDR_W:0]   sum;
  logic [srt_pkg::RND_W-1:0]  rnd;
  logic [srt_pkg::RND_W-1:0]  end_full;
  logic [srt_pkg::ADDR_W-1:0] start_addr;

  always_comb begin
    sum        = {1'b0, addr_i} + {1'b0, length_i};
    rnd        = {1'b0, sum} + srt_pkg::PAGE_MASK;
    end_full   = rnd & ~srt_pkg::PAGE_MASK;
    start_addr = addr_i & ~srt_pkg::PAGE_MASK[srt_pkg::ADDR_W-1:0];

    range_o.start_addr = start_addr;
    range_o.end_addr   = end_full[srt_pkg::ADDR_W-1:0];
    range_o.ok         = (user_base_i <= start_addr) &&
                         ({2'b00, start_addr} < end_full) &&
                         (end_full <= {2'b00, user_top_i});
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_region_table_core.sv =====
// Top level of the sorted region table: control sequencer, region memory and last-hit cache.
// Depends on srt_pkg and srt_range.
//
//   channel    direction  fields (lowest bit first)
//   s_axis     in         tuser: req_type; tdata: addr, length, flags
//   m_axis     out        tuser: status, hit; tdata: found_start, found_end, found_flags
//   cfg        in         cfg_idx_i: 0 user_base, 1 user_top; cfg_data_i: value
//
// One item at a time. A lookup checks the last-hit cache, then reads the regions in order
// until one holds the address or the end of the table is reached. An insert checks the
// window and the cache, reads the regions until it passes the key, then moves the later
// regions up and writes the new one. Scan and moves share the one memory read port.
// Reset clears the fill count and the cache; the region memory needs no clearing.
// A new item is taken while the previous result still waits in the output register.
`default_nettype none

module sorted_region_table_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // addr, length, flags, zero fill
  input  wire logic [srt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type
  input  wire logic                              s_axis_tuser,

  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // found_start, found_end, found_flags, zero fill
  output      logic [srt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status, hit
  output      logic [srt_pkg::OUT_USER_W-1:0]    m_axis_tuser,

  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [srt_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int AW = srt_pkg::ADDR_W;
  localparam int FW = srt_pkg::FLAG_W;
  localparam int IW = srt_pkg::IDX_W;
  localparam int CW = srt_pkg::CNT_W;

  srt_pkg::state_e  state_q, state_d;

  logic [AW-1:0]    user_base_q, user_top_q;

  logic             req_q, req_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    len_q, len_d;
  logic [FW-1:0]    flags_q, flags_d;
  logic [AW-1:0]    key_q, key_d;
  logic [AW-1:0]    end_q, end_d;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    sh_q, sh_d;
  logic [CW-1:0]    sh_m1;
  logic             nxt_valid_q, nxt_valid_d;
  logic [AW-1:0]    nxt_start_q, nxt_start_d;

  logic             cache_valid_q, cache_valid_d;
  srt_pkg::entry_t  cache_q, cache_d;

  srt_pkg::result_t res_q, res_d;
  logic             m_valid_q, m_valid_d;
  srt_pkg::result_t m_res_q, m_res_d;

  srt_pkg::entry_t  mem [srt_pkg::MAX_REGIONS];
  srt_pkg::entry_t  rd_data_q;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  srt_pkg::entry_t  wr_data;

  srt_pkg::range_t  rng;
  logic [AW-1:0]    key_c;
  logic             is_map;
  logic             cache_hit_c;
  logic             scan_end;
  logic             tbl_hit;
  logic             past_key;
  logic             full;
  logic             ovl;
  logic             shift_done;
  logic             out_free;
  srt_pkg::entry_t  new_entry;

  srt_range u_range (
    .addr_i      (addr_q),
    .length_i    (len_q),
    .user_base_i (user_base_q),
    .user_top_i  (user_top_q),
    .range_o     (rng)
  );

  always_comb begin
    is_map      = (req_q == srt_pkg::REQ_MAP);
    key_c       = is_map ? rng.start_addr : addr_q;
    cache_hit_c = cache_valid_q && (cache_q.start_addr <= key_c) && (key_c < cache_q.end_addr);
    scan_end    = (idx_q == count_q);
    tbl_hit     = (rd_data_q.start_addr <= key_q) && (key_q < rd_data_q.end_addr);
    past_key    = (rd_data_q.start_addr > key_q);
    full        = (count_q == CW'(srt_pkg::MAX_REGIONS));
    ovl         = nxt_valid_q && (end_q > nxt_start_q);
    shift_done  = (sh_q == pos_q);
    sh_m1       = sh_q - CW'(1);
    out_free    = !m_valid_q || m_axis_tready;
    new_entry.start_addr = key_q;
    new_entry.end_addr   = end_q;
    new_entry.flags      = flags_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = srt_pkg::ST_CHECK;
      end
      srt_pkg::ST_CHECK: begin
        if ((is_map && !rng.ok) || cache_hit_c) state_d = srt_pkg::ST_DONE;
        else state_d = srt_pkg::ST_SCAN_RD;
      end
      srt_pkg::ST_SCAN_RD: begin
        if (!scan_end) state_d = srt_pkg::ST_SCAN_EVAL;
        else if (is_map) state_d = srt_pkg::ST_POST;
        else state_d = srt_pkg::ST_DONE;
      end
      srt_pkg::ST_SCAN_EVAL: begin
        if (tbl_hit) state_d = srt_pkg::ST_DONE;
        else if (is_map && past_key) state_d = srt_pkg::ST_POST;
        else state_d = srt_pkg::ST_SCAN_RD;
      end
      srt_pkg::ST_POST: begin
        if (full || ovl) state_d = srt_pkg::ST_DONE;
        else state_d = srt_pkg::ST_SHIFT_RD;
      end
      srt_pkg::ST_SHIFT_RD: begin
        if (shift_done) state_d = srt_pkg::ST_DONE;
        else state_d = srt_pkg::ST_SHIFT_WR;
      end
      srt_pkg::ST_SHIFT_WR: begin
        state_d = srt_pkg::ST_SHIFT_RD;
      end
      srt_pkg::ST_DONE: begin
        if (out_free) state_d = srt_pkg::ST_IDLE;
      end
      default: state_d = srt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    req_d         = req_q;
    addr_d        = addr_q;
    len_d         = len_q;
    flags_d       = flags_q;
    key_d         = key_q;
    end_d         = end_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    sh_d          = sh_q;
    nxt_valid_d   = nxt_valid_q;
    nxt_start_d   = nxt_start_q;
    cache_valid_d = cache_valid_q;
    cache_d       = cache_q;
    res_d         = res_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_res_d       = m_res_q;
    rd_en         = 1'b0;
    rd_addr       = idx_q[IW-1:0];
    mem_we        = 1'b0;
    wr_addr       = sh_q[IW-1:0];
    wr_data       = rd_data_q;

    unique case (state_q)
      srt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d   = s_axis_tuser;
          addr_d  = s_axis_tdata[AW-1:0];
          len_d   = s_axis_tdata[2*AW-1:AW];
          flags_d = s_axis_tdata[2*AW+FW-1:2*AW];
        end
      end
      srt_pkg::ST_CHECK: begin
        key_d       = key_c;
        end_d       = rng.end_addr;
        idx_d       = '0;
        nxt_valid_d = 1'b0;
        res_d       = '0;
        if (is_map && !rng.ok) begin
          res_d.status = srt_pkg::STAT_INVALID;
        end else if (cache_hit_c) begin
          if (is_map) begin
            res_d.status = srt_pkg::STAT_INVALID;
          end else begin
            res_d.hit    = 1'b1;
            res_d.region = cache_q;
          end
        end
      end
      srt_pkg::ST_SCAN_RD: begin
        if (!scan_end) begin
          rd_en = 1'b1;
        end else begin
          pos_d = count_q;
        end
      end
      srt_pkg::ST_SCAN_EVAL: begin
        if (tbl_hit) begin
          cache_valid_d = 1'b1;
          cache_d       = rd_data_q;
          if (is_map) begin
            res_d.status = srt_pkg::STAT_INVALID;
          end else begin
            res_d.hit    = 1'b1;
            res_d.region = rd_data_q;
          end
        end else if (is_map && past_key) begin
          pos_d       = idx_q;
          nxt_valid_d = 1'b1;
          nxt_start_d = rd_data_q.start_addr;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      srt_pkg::ST_POST: begin
        if (full) res_d.status = srt_pkg::STAT_FULL;
        else if (ovl) res_d.status = srt_pkg::STAT_OVERLAP;
        else sh_d = count_q;
      end
      srt_pkg::ST_SHIFT_RD: begin
        if (shift_done) begin
          mem_we       = 1'b1;
          wr_addr      = pos_q[IW-1:0];
          wr_data      = new_entry;
          count_d      = count_q + CW'(1);
          res_d.status = srt_pkg::STAT_OK;
          res_d.hit    = 1'b1;
          res_d.region = new_entry;
        end else begin
          rd_en   = 1'b1;
          rd_addr = sh_m1[IW-1:0];
        end
      end
      srt_pkg::ST_SHIFT_WR: begin
        mem_we = 1'b1;
        sh_d   = sh_m1;
      end
      srt_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_res_d   = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srt_pkg::ST_IDLE;
      user_base_q   <= srt_pkg::USER_BASE_RST;
      user_top_q    <= srt_pkg::USER_TOP_RST;
      count_q       <= '0;
      cache_valid_q <= 1'b0;
      cache_q       <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      cache_valid_q <= cache_valid_d;
      cache_q       <= cache_d;
      m_valid_q     <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srt_pkg::CFG_USER_BASE: user_base_q <= cfg_data_i;
          srt_pkg::CFG_USER_TOP:  user_top_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    flags_q     <= flags_d;
    key_q       <= key_d;
    end_q       <= end_d;
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    sh_q        <= sh_d;
    nxt_valid_q <= nxt_valid_d;
    nxt_start_q <= nxt_start_d;
    res_q       <= res_d;
    m_res_q     <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{srt_pkg::OUT_PAD_W{1'b0}}, m_res_q.region};
  assign m_axis_tuser  = {m_res_q.hit, m_res_q.status};

endmodule

`default_nettype wire
